### design/rgbled_pkg.sv
package rgbled_pkg;

  // Width of the stored blink period
  localparam int PERIOD_BITS = 16;
  // Width of the blink_period field on the port
  localparam int PERIOD_IN_W = 16;
  localparam int PERIOD_EXT_W = (PERIOD_BITS > PERIOD_IN_W) ? PERIOD_BITS : PERIOD_IN_W;
  // A wait counter must hold a register value or half a blink period
  localparam int WAIT_W = (PERIOD_BITS - 1 > 16) ? PERIOD_BITS - 1 : 16;

  typedef logic [WAIT_W-1:0] wait_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  localparam wait_t WAIT_ONE = wait_t'(1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_MODE  = 2'd1;
  localparam cmd_t CMD_BLINK = 2'd2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_CYCLE  = 2'd0;
  localparam mode_t MODE_LOWBAT = 2'd1;
  localparam mode_t MODE_BLINK  = 2'd2;
  localparam mode_t MODE_IDLE   = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_CYCLE_HOLD   = 2'd0;
  localparam reg_idx_t REG_BREATHE_STEP = 2'd1;
  localparam reg_idx_t REG_IDLE_POLL    = 2'd2;

  localparam logic [15:0] CYCLE_HOLD_RESET   = 16'd1000;
  localparam logic [15:0] BREATHE_STEP_RESET = 16'd25;
  localparam logic [15:0] IDLE_POLL_RESET    = 16'd250;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t RGB_BLACK = '{red: 8'h00, green: 8'h00, blue: 8'h00};
  localparam rgb_t RGB_RED   = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
  localparam rgb_t RGB_GREEN = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
  localparam rgb_t RGB_BLUE  = '{red: 8'h00, green: 8'h00, blue: 8'hFF};

  localparam logic [7:0] BREATH_MIN = 8'h01;
  localparam logic [7:0] BREATH_MAX = 8'hFF;
  localparam logic [1:0] COLOUR_LAST = 2'd2;

  typedef struct packed {
    rgb_t  colour;
    logic  write;
    mode_t mode;
  } result_t;

  // Wait of zero counts as one tick
  function automatic wait_t at_least_one(input wait_t w);
    at_least_one = (w == '0) ? WAIT_ONE : w;
  endfunction

endpackage

### design/rgb_status_led_sequencer_top.sv
// A result beat is registered before it is offered; every accepted beat yields exactly one result beat.
// One input beat is accepted per cycle while in_stall is low.
// Output side has a result register plus one skid entry, so input accepts
// continue while a result waits; in_stall rises only when the skid entry is full.
// Reset (rst, synchronous, active high): registers to 1000/25/250, cycle mode,
// black LED, wait counter 0 so the first tick acts; no beats are pending.
module rgb_status_led_sequencer_top
  import rgbled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [1:0]  new_mode,
  input  logic [7:0]  blink_count,
  input  logic [15:0] blink_period,
  input  logic [7:0]  blink_red,
  input  logic [7:0]  blink_green,
  input  logic [7:0]  blink_blue,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  led_red,
  output logic [7:0]  led_green,
  output logic [7:0]  led_blue,
  output logic        led_write,
  output logic [1:0]  mode_now
);

  // Configuration registers
  logic [15:0] cycle_hold_ticks;
  logic [15:0] breathe_step_ticks;
  logic [15:0] idle_poll_ticks;

  // Sequencer state
  mode_t      mode, mode_next;
  mode_t      saved_mode, saved_mode_next;
  wait_t      wait_left, wait_left_next;
  logic [1:0] colour_index, colour_index_next;
  logic [7:0] breath_level, breath_level_next;
  logic       breath_rising, breath_rising_next;
  logic [7:0] blink_total, blink_total_next;
  period_t    blink_ticks, blink_ticks_next;
  rgb_t       blink_colour, blink_colour_next;
  logic [7:0] blinks_left, blinks_left_next;
  phase_t     blink_phase, blink_phase_next;
  rgb_t       led_colour, led_colour_next;
  logic       wrote;

  // Output buffering: result register and one skid entry
  logic    out_full;
  result_t out_data;
  logic    skid_full;
  result_t skid_data;
  result_t step_result;

  logic in_accept;
  logic out_take;

  // Working signals of the step
  logic                    act;         // tick that ran out the wait
  logic                    blink_act;
  logic                    plain_act;
  mode_t                   plain_mode;  // mode acted on by a plain action
  mode_t                   restored_mode;
  logic [7:0]              blinks_dec;
  wait_t                   half_wait;
  logic [PERIOD_EXT_W-1:0] period_ext;
  logic [7:0]              breath_stepped;
  logic                    rising_now;

  assign in_stall  = skid_full;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_full && !out_stall;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_hold_ticks   <= CYCLE_HOLD_RESET;
      breathe_step_ticks <= BREATHE_STEP_RESET;
      idle_poll_ticks    <= IDLE_POLL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CYCLE_HOLD:   cycle_hold_ticks   <= cfg_data;
        REG_BREATHE_STEP: breathe_step_ticks <= cfg_data;
        REG_IDLE_POLL:    idle_poll_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Period is kept in its low PERIOD_BITS bits
  assign period_ext = PERIOD_EXT_W'(blink_period);
  // Each blink phase lasts half a period, at least one tick
  assign half_wait  = at_least_one(wait_t'(blink_ticks >> 1));
  assign blinks_dec = (blinks_left == 8'd0) ? 8'd0 : blinks_left - 8'd1;
  assign restored_mode = (saved_mode == MODE_BLINK) ? MODE_IDLE : saved_mode;

  // Breathing direction turns at the ends of the ramp
  always_comb begin
    rising_now = breath_rising;
    if (breath_level == BREATH_MIN) begin
      rising_now = 1'b1;
    end else if (breath_level == BREATH_MAX) begin
      rising_now = 1'b0;
    end
    breath_stepped = rising_now ? {breath_level[6:0], 1'b1} : (breath_level >> 1);
  end

  // One step of the sequencer
  always_comb begin
    mode_next          = mode;
    saved_mode_next    = saved_mode;
    wait_left_next     = wait_left;
    colour_index_next  = colour_index;
    breath_level_next  = breath_level;
    breath_rising_next = breath_rising;
    blink_total_next   = blink_total;
    blink_ticks_next   = blink_ticks;
    blink_colour_next  = blink_colour;
    blinks_left_next   = blinks_left;
    blink_phase_next   = blink_phase;
    led_colour_next    = led_colour;
    wrote              = 1'b0;

    act        = (cmd == CMD_TICK) && (wait_left <= WAIT_ONE);
    blink_act  = act && (mode == MODE_BLINK);
    plain_act  = act && (mode != MODE_BLINK);
    plain_mode = mode;

    case (cmd)
      CMD_TICK: begin
        if (!act) begin
          wait_left_next = wait_left - WAIT_ONE;
        end
        if (blink_act) begin
          if (blink_phase == PH_ON) begin
            // colour shown: go dark for the second half
            led_colour_next  = RGB_BLACK;
            wrote            = 1'b1;
            blink_phase_next = PH_OFF;
            wait_left_next   = half_wait;
          end else begin
            blinks_left_next = (blink_phase == PH_OFF) ? blinks_dec : blink_total;
            if (blinks_left_next == 8'd0) begin
              // blink done: restore the saved mode and let it act now
              blink_phase_next = PH_NONE;
              mode_next        = restored_mode;
              plain_mode       = restored_mode;
              plain_act        = 1'b1;
            end else begin
              led_colour_next  = blink_colour;
              wrote            = 1'b1;
              blink_phase_next = PH_ON;
              wait_left_next   = half_wait;
            end
          end
        end
        if (plain_act) begin
          case (plain_mode)
            MODE_CYCLE: begin
              case (colour_index)
                2'd1:    led_colour_next = RGB_GREEN;
                2'd2:    led_colour_next = RGB_BLUE;
                default: led_colour_next = RGB_RED;
              endcase
              wrote             = 1'b1;
              colour_index_next = (colour_index >= COLOUR_LAST) ? 2'd0 : colour_index + 2'd1;
              wait_left_next    = at_least_one(wait_t'(cycle_hold_ticks));
            end
            MODE_LOWBAT: begin
              breath_rising_next = rising_now;
              breath_level_next  = breath_stepped;
              led_colour_next    = '{red: breath_stepped, green: 8'h00, blue: 8'h00};
              wrote              = 1'b1;
              wait_left_next     = at_least_one(wait_t'(breathe_step_ticks));
            end
            default: begin
              wait_left_next = at_least_one(wait_t'(idle_poll_ticks));
            end
          endcase
        end
      end
      CMD_MODE: begin
        // takes effect at once; running wait kept, any blink abandoned
        mode_next        = new_mode;
        blink_phase_next = PH_NONE;
      end
      CMD_BLINK: begin
        if (mode != MODE_BLINK) begin
          saved_mode_next   = mode;
          mode_next         = MODE_BLINK;
          blink_total_next  = blink_count;
          blink_ticks_next  = period_ext[PERIOD_BITS-1:0];
          blink_colour_next = '{red: blink_red, green: blink_green, blue: blink_blue};
          blinks_left_next  = 8'd0;
          blink_phase_next  = PH_NONE;
        end
      end
      default: ;
    endcase

    step_result = '{colour: led_colour_next, write: wrote, mode: mode_next};
  end

  // Advance the state on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_CYCLE;
      saved_mode    <= MODE_CYCLE;
      wait_left     <= '0;
      colour_index  <= 2'd0;
      breath_level  <= BREATH_MIN;
      breath_rising <= 1'b1;
      blink_total   <= 8'd0;
      blink_ticks   <= '0;
      blink_colour  <= RGB_BLACK;
      blinks_left   <= 8'd0;
      blink_phase   <= PH_NONE;
      led_colour    <= RGB_BLACK;
    end else if (in_accept) begin
      mode          <= mode_next;
      saved_mode    <= saved_mode_next;
      wait_left     <= wait_left_next;
      colour_index  <= colour_index_next;
      breath_level  <= breath_level_next;
      breath_rising <= breath_rising_next;
      blink_total   <= blink_total_next;
      blink_ticks   <= blink_ticks_next;
      blink_colour  <= blink_colour_next;
      blinks_left   <= blinks_left_next;
      blink_phase   <= blink_phase_next;
      led_colour    <= led_colour_next;
    end
  end

  // Result register with skid entry: the skid catches a beat accepted while
  // the result register is held, and drains first once it moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || out_take) begin
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full <= in_accept;
      end
    end else if (in_accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_take) begin
      if (skid_full) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= step_result;
      end
    end else if (in_accept) begin
      skid_data <= step_result;
    end
  end

  assign out_valid = out_full;
  assign led_red   = out_data.colour.red;
  assign led_green = out_data.colour.green;
  assign led_blue  = out_data.colour.blue;
  assign led_write = out_data.write;
  assign mode_now  = out_data.mode;

  // The skid entry is only ever used behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid entry full while result register empty");

  // A tick that does not run out the wait only counts down
  a_wait_countdown: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd == CMD_TICK && wait_left > WAIT_ONE)
      |=> wait_left == $past(wait_left) - WAIT_ONE)
    else $error("wait counter did not count down by one");

  // Every accepted tick leaves a nonzero wait behind
  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd == CMD_TICK) |=> wait_left != '0)
    else $error("wait counter left at zero after a tick");

  // Outside blink mode no blink phase may be in progress
  a_phase_only_in_blink: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_BLINK |-> blink_phase == PH_NONE)
    else $error("blink phase active outside blink mode");

endmodule
